[sv/lptd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptd_pkg
// shared types and constants for lidar point time and decimate
// ----------------------------------------------------------------------------
package lptd_pkg;

	localparam int CoordW     = 19;
	localparam int RingW      = 7;
	localparam int RawW       = 20;
	localparam int TimeW      = 18;
	localparam int GainW      = 24;
	localparam int YawW       = 17;
	localparam int CfgDataW   = 24;
	localparam int CfgIdxW    = 2;
	localparam int NumRingsDef = 128;
	localparam int CordicIters = 18;
	localparam int AccW       = 26;
	localparam int CvW        = 30;

	localparam logic [CfgIdxW-1:0] RegStep  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegRings = 2'd1;
	localparam logic [CfgIdxW-1:0] RegGain  = 2'd2;
	localparam logic [CfgIdxW-1:0] RegMode  = 2'd3;

	localparam logic [39:0] RangeSq     = 40'd16000000;
	localparam logic [AccW-1:0] HalfTurn = 26'd11796480;
	localparam logic [YawW:0] FullTurnYaw = 18'd92160;
	localparam logic [TimeW:0] WrapTime  = 19'd102116;
	localparam logic [TimeW-1:0] TimeMax = 18'h3FFFF;

	typedef struct packed {
		logic                     clr;
		logic                     live;
		logic                     emit;
		logic                     yaw_mode;
		logic                     ring_ok;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic [RingW-1:0]         ring;
		logic [TimeW-1:0]         raw_t;
	} lptd_job_t;

	function automatic logic [AccW-1:0] atan_lut(input logic [4:0] i);
		case (i)
			5'd0:  atan_lut = 26'd2949120;
			5'd1:  atan_lut = 26'd1740967;
			5'd2:  atan_lut = 26'd919879;
			5'd3:  atan_lut = 26'd466945;
			5'd4:  atan_lut = 26'd234379;
			5'd5:  atan_lut = 26'd117304;
			5'd6:  atan_lut = 26'd58666;
			5'd7:  atan_lut = 26'd29335;
			5'd8:  atan_lut = 26'd14668;
			5'd9:  atan_lut = 26'd7334;
			5'd10: atan_lut = 26'd3667;
			5'd11: atan_lut = 26'd1833;
			5'd12: atan_lut = 26'd917;
			5'd13: atan_lut = 26'd458;
			5'd14: atan_lut = 26'd229;
			5'd15: atan_lut = 26'd115;
			5'd16: atan_lut = 26'd57;
			5'd17: atan_lut = 26'd29;
			default: atan_lut = '0;
		endcase
	endfunction

endpackage

[sv/lidar_point_time_and_decimate_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_time_and_decimate_top
// lidar point range filter, per-ring yaw timing and decimation
// ----------------------------------------------------------------------------
// A front stage takes one word at a time and accepts no new word until it is
// through with it (range test, decimation phase, raw time scaling); it hands
// the word to a back stage together with the cloud clear unless it drops it
// there, and a dropped first word of a cloud still goes back. In yaw mode the
// back stage runs each point through its 18-step shared cordic, while raw-time
// points pass straight to the output. Results sit in an output register.
module lidar_point_time_and_decimate_top #(
	parameter int NUM_RINGS = lptd_pkg::NumRingsDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lptd_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [lptd_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               first_of_cloud,
	input  logic signed [lptd_pkg::CoordW-1:0] pos_x,
	input  logic signed [lptd_pkg::CoordW-1:0] pos_y,
	input  logic signed [lptd_pkg::CoordW-1:0] pos_z,
	input  logic [lptd_pkg::RingW-1:0]         ring,
	input  logic [lptd_pkg::RawW-1:0]          raw_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lptd_pkg::CoordW-1:0] pt_x,
	output logic signed [lptd_pkg::CoordW-1:0] pt_y,
	output logic signed [lptd_pkg::CoordW-1:0] pt_z,
	output logic [lptd_pkg::TimeW-1:0]         pt_time
);
	import lptd_pkg::*;

	logic [7:0] step_q, rings_q;
	logic [GainW-1:0] gain_q;
	logic mode_q;
	logic job_valid, job_ready;
	lptd_job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 8'd1;
			rings_q <= 8'd32;
			gain_q <= 24'd65536;
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				RegStep:  step_q <= cfg_data[7:0];
				RegRings: rings_q <= cfg_data[7:0];
				RegGain:  gain_q <= cfg_data;
				RegMode:  mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lptd_front #(.NUM_RINGS(NUM_RINGS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .first_of_cloud,
		.pos_x, .pos_y, .pos_z, .ring, .raw_time,
		.step(step_q), .rings_in_use(rings_q), .gain(gain_q), .yaw_mode(mode_q),
		.job_valid, .job_ready, .job
	);

	lptd_back #(.NUM_RINGS(NUM_RINGS)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.out_valid, .out_ready, .pt_x, .pt_y, .pt_z, .pt_time
	);
endmodule

[sv/lptd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptd_front
// accepts points, runs range test, decimation phase and raw time scaling
// ----------------------------------------------------------------------------
module lptd_front #(
	parameter int NUM_RINGS = lptd_pkg::NumRingsDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              first_of_cloud,
	input  logic signed [lptd_pkg::CoordW-1:0] pos_x,
	input  logic signed [lptd_pkg::CoordW-1:0] pos_y,
	input  logic signed [lptd_pkg::CoordW-1:0] pos_z,
	input  logic [lptd_pkg::RingW-1:0]         ring,
	input  logic [lptd_pkg::RawW-1:0]          raw_time,
	input  logic [7:0]                         step,
	input  logic [7:0]                         rings_in_use,
	input  logic [lptd_pkg::GainW-1:0]         gain,
	input  logic                               yaw_mode,
	output logic                               job_valid,
	input  logic                               job_ready,
	output lptd_pkg::lptd_job_t                job
);
	import lptd_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_SQ, F_SUM, F_OUT} fstate_t;

	fstate_t state_q;
	logic [7:0] phase_q;
	lptd_job_t job_q;
	logic [39:0] sq_x_q, sq_y_q, sq_z_q;
	logic [43:0] prod_q;
	logic far_q;
	logic [7:0] stp;
	logic [7:0] ph;
	logic [8:0] ph_n;
	logic [TimeW+1:0] tq;
	logic drop;

	assign stp = (step == 8'd0) ? 8'd1 : step;
	assign ph = first_of_cloud ? 8'd0 : phase_q;
	assign ph_n = {1'b0, ph} + 9'd1;
	assign in_ready = (state_q == F_IDLE);
	assign job_valid = (state_q == F_OUT);
	assign job = job_q;
	assign tq = (prod_q[43:36] != 8'd0) ? {2'b00, TimeMax} : prod_q[35:16];
	assign drop = !far_q || (job_q.yaw_mode && !job_q.ring_ok) ||
		(!job_q.yaw_mode && !job_q.emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			phase_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						phase_q <= (ph_n >= {1'b0, stp}) ? 8'd0 : ph_n[7:0];
						job_q.clr <= first_of_cloud;
						job_q.emit <= (ph == 8'd0);
						job_q.yaw_mode <= yaw_mode;
						job_q.ring_ok <= ({1'b0, ring} < {1'b0, rings_in_use}) &&
							(32'(ring) < NUM_RINGS);
						job_q.x <= pos_x;
						job_q.y <= pos_y;
						job_q.z <= pos_z;
						job_q.ring <= ring;
						sq_x_q <= 40'(pos_x * pos_x);
						sq_y_q <= 40'(pos_y * pos_y);
						sq_z_q <= 40'(pos_z * pos_z);
						prod_q <= 44'({20'd0, raw_time} * {20'd0, gain}) + 44'd32768;
						state_q <= F_SQ;
					end
				end
				F_SQ: begin
					far_q <= (sq_x_q + sq_y_q + sq_z_q) >= RangeSq;
					job_q.raw_t <= (tq > {2'b00, TimeMax}) ? TimeMax : tq[TimeW-1:0];
					state_q <= F_SUM;
				end
				F_SUM: begin
					// a dropped first word of a cloud still goes back to clear ring flags
					job_q.live <= !drop;
					if (drop && !job_q.clr)
						state_q <= F_IDLE;
					else
						state_q <= F_OUT;
				end
				F_OUT: begin
					if (job_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

[sv/lptd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptd_back
// per-ring yaw timing through an iterative cordic, and result output register
// ----------------------------------------------------------------------------
module lptd_back #(
	parameter int NUM_RINGS = lptd_pkg::NumRingsDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	output logic                               job_ready,
	input  lptd_pkg::lptd_job_t                job,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lptd_pkg::CoordW-1:0] pt_x,
	output logic signed [lptd_pkg::CoordW-1:0] pt_y,
	output logic signed [lptd_pkg::CoordW-1:0] pt_z,
	output logic [lptd_pkg::TimeW-1:0]         pt_time
);
	import lptd_pkg::*;

	localparam int RiW = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;

	typedef enum logic [2:0] {B_IDLE, B_CORD, B_YAW, B_DIV, B_DIV2, B_FIN} bstate_t;

	bstate_t state_q;
	lptd_job_t job_q;
	logic [NUM_RINGS-1:0] started_q;
	logic [YawW-1:0] first_yaw_mem [NUM_RINGS];
	logic [TimeW-1:0] last_time_mem [NUM_RINGS];
	logic [YawW-1:0] fy_q;
	logic [TimeW-1:0] lt_q;
	logic signed [CvW-1:0] cx_q, cy_q;
	logic signed [AccW-1:0] acc_q;
	logic [4:0] it_q;
	logic signed [YawW-1:0] yaw_q;
	logic [25:0] num_q;
	logic [TimeW:0] t_q;
	logic [RiW-1:0] ri;
	logic signed [CvW-1:0] dx, dy;
	logic signed [AccW-1:0] accr;
	logic signed [YawW:0] diff;
	logic signed [YawW:0] dwrap;
	logic [YawW:0] dsel;
	logic [TimeW+1:0] tw;
	logic [TimeW-1:0] tsat;
	logic [54:0] recip_prod;
	logic ostall;

	assign ri = RiW'(job_q.ring);
	assign dx = cy_q >>> it_q;
	assign dy = cx_q >>> it_q;
	assign accr = acc_q + AccW'(128);
	assign diff = $signed({fy_q[YawW-1], fy_q}) - $signed({yaw_q[YawW-1], yaw_q});
	assign dwrap = diff + $signed(FullTurnYaw);
	assign dsel = (diff >= 0) ? diff[YawW:0] : (dwrap[YawW] ? '0 : dwrap[YawW:0]);
	assign ostall = out_valid && !out_ready;
	assign job_ready = (state_q == B_IDLE) && !ostall;
	assign tw = {1'b0, t_q} + ((t_q < {1'b0, lt_q}) ? {1'b0, WrapTime} : '0);
	assign tsat = (tw > {2'b00, TimeMax}) ? TimeMax : tw[TimeW-1:0];

	// d*400+180 times ceil(2^36/361) then shift
	assign recip_prod = {29'd0, num_q} * 55'd190358662;

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && job_valid && !ostall) begin
			fy_q <= first_yaw_mem[RiW'(job.ring)];
			lt_q <= last_time_mem[RiW'(job.ring)];
		end
		if (state_q == B_DIV && !started_q[ri]) begin
			first_yaw_mem[ri] <= yaw_q;
			last_time_mem[ri] <= '0;
		end else if (state_q == B_FIN && job_q.yaw_mode) begin
			last_time_mem[ri] <= tsat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			started_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (job_valid && !ostall) begin
						job_q <= job;
						if (job.clr)
							started_q <= '0;
						if (job.live) begin
							if (job.yaw_mode) begin
								it_q <= '0;
								if (job.x < 0) begin
									cx_q <= -(CvW'(job.x) <<< 8);
									cy_q <= -(CvW'(job.y) <<< 8);
									acc_q <= job.y[CoordW-1] ? -$signed(HalfTurn)
										: $signed(HalfTurn);
								end else begin
									cx_q <= CvW'(job.x) <<< 8;
									cy_q <= CvW'(job.y) <<< 8;
									acc_q <= '0;
								end
								state_q <= B_CORD;
							end else begin
								t_q <= {1'b0, job.raw_t};
								state_q <= B_FIN;
							end
						end
					end
				end
				B_CORD: begin
					if (cy_q >= 0) begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						acc_q <= acc_q + $signed(atan_lut(it_q));
					end else begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						acc_q <= acc_q - $signed(atan_lut(it_q));
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'(CordicIters - 1))
						state_q <= B_YAW;
				end
				B_YAW: begin
					yaw_q <= YawW'(accr >>> 8);
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (!started_q[ri]) begin
						started_q[ri] <= 1'b1;
						state_q <= B_IDLE;
					end else begin
						num_q <= 26'({8'd0, dsel} * 26'd400) + 26'd180;
						state_q <= B_DIV2;
					end
				end
				B_DIV2: begin
					t_q <= recip_prod[TimeW+36:36];
					state_q <= B_FIN;
				end
				B_FIN: begin
					if (job_q.emit) begin
						out_valid <= 1'b1;
						pt_x <= job_q.x;
						pt_y <= job_q.y;
						pt_z <= job_q.z;
						pt_time <= job_q.yaw_mode ? tsat : t_q[TimeW-1:0];
					end
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
